// ===== rtl/scwrms_pkg.sv =====
// shared constants for the six channel windowed rms meter
`timescale 1ns / 1ps
`default_nettype none

package scwrms_pkg;

  localparam int CHANNELS      = 6;
  localparam int SAMPLE_W      = 16;
  localparam int SQUARE_W      = 2 * SAMPLE_W;
  localparam int RMS_W         = 15;
  localparam int FRAME_W       = 32;
  localparam int WLEN_W        = 8;
  localparam int SCALE_W       = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int SUM_WIDTH_DEF = 38;
  localparam int MEAN_FRAC     = 8;
  localparam int SCALE_SHIFT   = 20;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16     = 1'd1;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = 8'd39;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd39976;
  localparam logic [RMS_W-1:0]   RMS_MAX     = 15'h7fff;

endpackage

`default_nettype wire

// ===== rtl/six_channel_windowed_rms.sv =====
// six channel windowed rms meter: accumulators in a small ram, shared divide, root, scale
//
// usage
//   input channel: one beat is a frame of six signed 16-bit samples (in_sample_0..5),
//   taken when in_valid is high and in_stall is low. result channel: one beat carries
//   the running frame total and six scaled rms values, offered on out_valid and taken
//   when out_stall is low. the user writes window length and scale through cfg_we,
//   cfg_index and cfg_wdata only while the block is idle; the block does not enforce it.
// timing
//   frames are handled one at a time. the sums live in a one-port ram with a registered
//   read, so each channel takes a read state and a write state: a frame that does not
//   close the window keeps in_stall high until the last channel has been written back.
//   a closing frame runs, per channel, the read/write pair, a restoring divide by the
//   window length, a bit-pair square root, a multiply step and a saturate step, then
//   waits in ST_OUT_WAIT until the result register can be loaded.
// reset and stall
//   reset clears the sums (through per-entry valid bits), window position and frame
//   total and restores the register defaults. a stalled result holds in the output
//   register; further frames are still accumulated, and only the next closing frame
//   waits until the held result has been taken.
`timescale 1ns / 1ps
`default_nettype none

module six_channel_windowed_rms #(
  parameter int SUM_WIDTH = scwrms_pkg::SUM_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // configuration
  input  wire                                   cfg_we,
  input  wire  [scwrms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [scwrms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input frames
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_0,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_1,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_2,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_3,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_4,
  input  wire  signed [scwrms_pkg::SAMPLE_W-1:0] in_sample_5,
  // results
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [scwrms_pkg::FRAME_W-1:0]        out_frame_count,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_0,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_1,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_2,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_3,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_4,
  output logic [scwrms_pkg::RMS_W-1:0]          out_rms_5
);

  localparam int CH_N    = scwrms_pkg::CHANNELS;
  localparam int CH_W    = $clog2(CH_N);
  localparam int SMP_W   = scwrms_pkg::SAMPLE_W;
  localparam int SQ_W    = scwrms_pkg::SQUARE_W;
  localparam int RMS_W   = scwrms_pkg::RMS_W;
  localparam int WLEN_W  = scwrms_pkg::WLEN_W;
  localparam int SCALE_W = scwrms_pkg::SCALE_W;
  localparam int FRAME_W = scwrms_pkg::FRAME_W;
  // dividend is the sum with 8 fraction bits appended
  localparam int DW      = SUM_WIDTH + scwrms_pkg::MEAN_FRAC;
  // root width and padded radicand width
  localparam int RW      = (DW + 1) / 2;
  localparam int VW      = 2 * RW;
  localparam int PROD_W  = RW + SCALE_W;
  localparam int HI_W    = PROD_W - scwrms_pkg::SCALE_SHIFT;
  localparam int STEP_W  = $clog2(DW);

  // sequencer codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ACC_RD   = 3'd1;
  localparam logic [2:0] ST_ACC_WR   = 3'd2;
  localparam logic [2:0] ST_DIV      = 3'd3;
  localparam logic [2:0] ST_SQRT     = 3'd4;
  localparam logic [2:0] ST_MUL      = 3'd5;
  localparam logic [2:0] ST_SAT      = 3'd6;
  localparam logic [2:0] ST_OUT_WAIT = 3'd7;

  // control state
  logic [2:0]          state_r;
  logic [CH_W-1:0]     ch_r;
  logic [STEP_W-1:0]   step_r;
  logic [WLEN_W-1:0]   wpos_r;
  logic [FRAME_W-1:0]  total_r;
  logic                close_r;
  logic [CH_N-1:0]     vld_r;
  logic                out_valid_r;
  logic [WLEN_W-1:0]   wlen_r;
  logic [SCALE_W-1:0]  scale_r;

  // accumulator ram
  logic [SUM_WIDTH-1:0] sum_mem [CH_N];
  logic [SUM_WIDTH-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic                 mem_we;
  logic [SUM_WIDTH-1:0] mem_wdata;

  // datapath
  logic [SMP_W-1:0]     sample_r [CH_N];
  logic [SMP_W-1:0]     in_sample [CH_N];
  logic [SMP_W-1:0]     cur_sample;
  logic [SMP_W-1:0]     mag;
  logic [SQ_W-1:0]      sq_r;
  logic [SUM_WIDTH-1:0] new_sum;
  logic [WLEN_W-1:0]    len_eff;
  logic [WLEN_W-1:0]    len_r;
  logic                 close_nxt;

  logic [DW-1:0]        q_r;
  logic [DW-1:0]        q_nxt;
  logic [WLEN_W-1:0]    drem_r;
  logic [WLEN_W-1:0]    drem_nxt;
  logic [WLEN_W:0]      drem_sh;

  logic [VW-1:0]        v_r;
  logic [RW:0]          srem_r;
  logic [RW:0]          srem_nxt;
  logic [RW+2:0]        srem_sh;
  logic [RW+2:0]        trial;
  logic [RW-1:0]        root_r;
  logic [RW-1:0]        root_nxt;

  logic [PROD_W-1:0]    prod_r;
  logic [HI_W-1:0]      prod_hi;
  logic [RMS_W-1:0]     rms_sat;
  logic [RMS_W-1:0]     res_r [CH_N];

  logic [FRAME_W-1:0]   out_frame_r;
  logic [RMS_W-1:0]     out_rms_r [CH_N];

  logic                 in_acc;
  logic                 last_ch;
  logic                 out_load;

  assign in_sample[0] = in_sample_0;
  assign in_sample[1] = in_sample_1;
  assign in_sample[2] = in_sample_2;
  assign in_sample[3] = in_sample_3;
  assign in_sample[4] = in_sample_4;
  assign in_sample[5] = in_sample_5;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign last_ch  = (ch_r == CH_W'(CH_N - 1));
  assign out_load = (state_r == ST_OUT_WAIT) && (!out_valid_r || !out_stall);

  // a zero window length acts as one
  assign len_eff   = (wlen_r == '0) ? WLEN_W'(1) : wlen_r;
  assign close_nxt = ({1'b0, wpos_r} + (WLEN_W + 1)'(1)) >= {1'b0, len_eff};

  // magnitude of the selected sample; the most negative code maps to 0x8000
  assign cur_sample = sample_r[ch_r];
  assign mag        = cur_sample[SMP_W-1] ? (~cur_sample + SMP_W'(1)) : cur_sample;

  // sum read back from the ram, entries never written read as zero
  assign new_sum = (rd_vld_r ? rd_data_r : '0) + SUM_WIDTH'(sq_r);

  // a closing frame hands its sum to the divider and clears the entry
  assign mem_we    = (state_r == ST_ACC_WR);
  assign mem_wdata = close_r ? '0 : new_sum;

  // restoring divide step, one quotient bit per cycle
  always_comb begin
    drem_sh = {drem_r, q_r[DW-1]};
    if (drem_sh >= {1'b0, len_r}) begin
      drem_nxt = WLEN_W'(drem_sh - {1'b0, len_r});
      q_nxt    = {q_r[DW-2:0], 1'b1};
    end else begin
      drem_nxt = drem_sh[WLEN_W-1:0];
      q_nxt    = {q_r[DW-2:0], 1'b0};
    end
  end

  // square root step, one root bit per cycle from two radicand bits
  always_comb begin
    srem_sh = {srem_r, v_r[VW-1:VW-2]};
    trial   = {1'b0, root_r, 2'b01};
    if (srem_sh >= trial) begin
      srem_nxt = (RW + 1)'(srem_sh - trial);
      root_nxt = {root_r[RW-2:0], 1'b1};
    end else begin
      srem_nxt = srem_sh[RW:0];
      root_nxt = {root_r[RW-2:0], 1'b0};
    end
  end

  // drop the scale fraction and clip to the result range
  assign prod_hi = prod_r[PROD_W-1:scwrms_pkg::SCALE_SHIFT];
  assign rms_sat = (prod_hi > HI_W'(scwrms_pkg::RMS_MAX)) ? scwrms_pkg::RMS_MAX
                                                           : prod_hi[RMS_W-1:0];

  // accumulator ram, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[ch_r] <= mem_wdata;
    end
    rd_data_r <= sum_mem[ch_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= scwrms_pkg::WLEN_RESET;
      scale_r <= scwrms_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scwrms_pkg::REG_WINDOW_LENGTH: wlen_r  <= cfg_wdata[WLEN_W-1:0];
        scwrms_pkg::REG_SCALE_Q16:     scale_r <= cfg_wdata[SCALE_W-1:0];
      endcase
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      step_r      <= '0;
      wpos_r      <= '0;
      total_r     <= '0;
      close_r     <= 1'b0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[ch_r];
      if (mem_we) begin
        vld_r[ch_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            total_r <= total_r + FRAME_W'(1);
            close_r <= close_nxt;
            wpos_r  <= close_nxt ? '0 : wpos_r + WLEN_W'(1);
            ch_r    <= '0;
            state_r <= ST_ACC_RD;
          end
        end
        ST_ACC_RD: begin
          state_r <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          if (close_r) begin
            step_r  <= STEP_W'(DW - 1);
            state_r <= ST_DIV;
          end else if (last_ch) begin
            state_r <= ST_IDLE;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            state_r <= ST_ACC_RD;
          end
        end
        ST_DIV: begin
          if (step_r == '0) begin
            step_r  <= STEP_W'(RW - 1);
            state_r <= ST_SQRT;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_SQRT: begin
          if (step_r == '0) begin
            state_r <= ST_MUL;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_MUL: begin
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          if (last_ch) begin
            state_r <= ST_OUT_WAIT;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            state_r <= ST_ACC_RD;
          end
        end
        ST_OUT_WAIT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < CH_N; i++) begin
        sample_r[i] <= in_sample[i];
      end
      len_r <= len_eff;
    end
    if (state_r == ST_ACC_RD) begin
      sq_r <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (state_r == ST_ACC_WR) begin
      q_r    <= {new_sum, {scwrms_pkg::MEAN_FRAC{1'b0}}};
      drem_r <= '0;
    end
    if (state_r == ST_DIV) begin
      q_r    <= q_nxt;
      drem_r <= drem_nxt;
      if (step_r == '0) begin
        v_r    <= VW'(q_nxt);
        srem_r <= '0;
        root_r <= '0;
      end
    end
    if (state_r == ST_SQRT) begin
      v_r    <= {v_r[VW-3:0], 2'b00};
      srem_r <= srem_nxt;
      root_r <= root_nxt;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(root_r) * PROD_W'(scale_r);
    end
    if (state_r == ST_SAT) begin
      res_r[ch_r] <= rms_sat;
    end
    if (out_load) begin
      out_frame_r <= total_r;
      for (int i = 0; i < CH_N; i++) begin
        out_rms_r[i] <= res_r[i];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_count = out_frame_r;
  assign out_rms_0       = out_rms_r[0];
  assign out_rms_1       = out_rms_r[1];
  assign out_rms_2       = out_rms_r[2];
  assign out_rms_3       = out_rms_r[3];
  assign out_rms_4       = out_rms_r[4];
  assign out_rms_5       = out_rms_r[5];

  // a new result only appears after the sequencer has finished all channels
  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT_WAIT)
    else $error("result raised outside the result load");

  // the result carries the frame total of the closing frame
  a_out_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> out_frame_r == total_r)
    else $error("result frame count differs from the running total");

  // divider remainder stays below the latched window length
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> drem_r < len_r)
    else $error("divider remainder out of range");

  // ram accesses stay inside the channel range
  a_ram_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ch_r < CH_W'(CH_N) || CH_N == (1 << CH_W))
    else $error("accumulator write beyond the last channel");

endmodule

`default_nettype wire
